// ----- rtl/bpt_pkg.sv -----
`timescale 1ns / 1ps

package bpt_pkg;

  // fixed field widths
  localparam int LaneFieldW = 5;
  localparam int ByteW      = 8;
  localparam int WordW      = 32;
  localparam int PlaneIdxW  = 5;
  localparam int PackedW    = 24;

  typedef struct packed {
    logic [LaneFieldW-1:0] lane;
    logic [ByteW-1:0]      red;
    logic [ByteW-1:0]      green;
    logic [ByteW-1:0]      blue;
    logic                  end_of_group;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0]     plane_word;
    logic [PlaneIdxW-1:0] plane_index;
    logic                 last;
  } out_item_t;

endpackage

// ----- rtl/bpt_accum.sv -----
`timescale 1ns / 1ps

module bpt_accum #(
  parameter int LANES      = 32,
  parameter int COLOR_BITS = 24
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  bpt_pkg::in_item_t                       in_data_i,
  output logic                                    in_stall_o,
  input  logic                                    bank_ready_i,
  output logic                                    bank_load_o,
  output logic [COLOR_BITS-1:0][bpt_pkg::WordW-1:0] bank_planes_o
);
  import bpt_pkg::*;

  localparam int AccW = (LANES < WordW) ? LANES : WordW;

  logic [COLOR_BITS-1:0][AccW-1:0] acc_q, acc_d, merged;
  logic [PackedW-1:0]              grb;
  logic [AccW-1:0]                 lane_mask;
  logic                            lane_ok;
  logic                            accept;

  assign grb       = {in_data_i.green, in_data_i.red, in_data_i.blue};
  assign lane_ok   = (32'(in_data_i.lane) < 32'(LANES));
  assign lane_mask = lane_ok ? (AccW'(1) << in_data_i.lane) : '0;

  // a group end can only go once the output bank is free
  assign in_stall_o = in_valid_i && in_data_i.end_of_group && !bank_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  // plane p carries packed bit COLOR_BITS-1-p, zero above the packed colour
  for (genvar p = 0; p < COLOR_BITS; p++) begin : g_plane
    localparam int Pos = COLOR_BITS - 1 - p;
    if (Pos < PackedW) begin : g_bit
      assign merged[p] = acc_q[p] | (grb[Pos] ? lane_mask : '0);
    end else begin : g_zero
      assign merged[p] = acc_q[p];
    end
    assign bank_planes_o[p] = WordW'(merged[p]);
  end

  assign bank_load_o = accept && in_data_i.end_of_group;

  always_comb begin
    acc_d = acc_q;
    if (accept) begin
      acc_d = in_data_i.end_of_group ? '0 : merged;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  a_clear_after_group : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_load_o |=> (acc_q == '0))
    else $error("accumulator not cleared after group end");

  a_stall_only_on_group_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_data_i.end_of_group && !bank_ready_i))
    else $error("input stalled without a pending group end");

  a_no_stall_when_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && bank_ready_i) |-> !in_stall_o)
    else $error("input stalled while bank free");

endmodule

// ----- rtl/bpt_drain.sv -----
`timescale 1ns / 1ps

module bpt_drain #(
  parameter int COLOR_BITS = 24
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      bank_load_i,
  input  logic [COLOR_BITS-1:0][bpt_pkg::WordW-1:0] bank_planes_i,
  output logic                                      bank_ready_o,
  output logic                                      out_valid_o,
  output bpt_pkg::out_item_t                        out_data_o,
  input  logic                                      out_stall_i
);
  import bpt_pkg::*;

  localparam int IdxW = $clog2(COLOR_BITS);

  logic [COLOR_BITS-1:0][WordW-1:0] bank_q;
  logic [IdxW-1:0]                  idx_q, idx_d;
  logic                             busy_q, busy_d;
  logic                             at_last;
  logic                             advance;

  assign at_last      = (idx_q == IdxW'(COLOR_BITS - 1));
  assign advance      = busy_q && !out_stall_i;
  // bank may be reloaded in the cycle its final word leaves
  assign bank_ready_o = !busy_q || (advance && at_last);

  assign out_valid_o            = busy_q;
  assign out_data_o.plane_word  = bank_q[idx_q];
  assign out_data_o.plane_index = PlaneIdxW'(idx_q);
  assign out_data_o.last        = at_last;

  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    if (bank_load_i) begin
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (advance) begin
      if (at_last) begin
        busy_d = 1'b0;
        idx_d  = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bank_load_i) begin
      bank_q <= bank_planes_i;
    end
  end

  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= IdxW'(COLOR_BITS - 1)))
    else $error("plane index out of range");

  a_load_only_when_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_load_i |-> bank_ready_o)
    else $error("bank overwritten while draining");

  a_restart_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && at_last) |=> (!busy_q || idx_q == '0))
    else $error("drain did not restart at plane zero");

  a_step_by_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !at_last && !bank_load_i) |=> (idx_q == $past(idx_q) + IdxW'(1)))
    else $error("plane index skipped");

endmodule

// ----- rtl/led_bitplane_transposer_core.sv -----
`timescale 1ns / 1ps

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------------
// in       | in        | in_valid_i/in_stall_o | in_data_i  (lane, rgb, group end)
// out      | out       | out_valid_o/out_stall_i | out_data_o (plane word, index, last)
//
// one input transaction is taken per cycle while in is not stalled; its colour
// bits are merged into the plane accumulator in the same cycle
// a group end copies the merged planes into the output bank register and
// the bank then sends COLOR_BITS plane words, one per cycle while out is not stalled
// input is only stalled by a group end arriving while the bank still holds
// words to send; the bank frees in the cycle its last word is taken
// reset clears the accumulator and empties the bank; no clearing pass

module led_bitplane_transposer_core #(
  parameter int LANES      = 32,
  parameter int COLOR_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bpt_pkg::in_item_t   in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output bpt_pkg::out_item_t  out_data_o,
  input  logic                out_stall_i
);
  import bpt_pkg::*;

  // merged planes handed from the accumulator to the output bank
  logic [COLOR_BITS-1:0][WordW-1:0] bank_planes;
  logic                             bank_load;
  logic                             bank_ready;

  // lane merge and group-end hand-off
  bpt_accum #(
    .LANES      (LANES),
    .COLOR_BITS (COLOR_BITS)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .in_stall_o    (in_stall_o),
    .bank_ready_i  (bank_ready),
    .bank_load_o   (bank_load),
    .bank_planes_o (bank_planes)
  );

  // output bank, sends planes in bit-time order
  bpt_drain #(
    .COLOR_BITS (COLOR_BITS)
  ) u_drain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bank_load_i   (bank_load),
    .bank_planes_i (bank_planes),
    .bank_ready_o  (bank_ready),
    .out_valid_o   (out_valid_o),
    .out_data_o    (out_data_o),
    .out_stall_i   (out_stall_i)
  );

endmodule
